FILE: rtl/cei_pkg.sv
// shared types, fixed-point constants and latency figures for the
// complete elliptic integral pipeline; no dependencies
`default_nettype none

package cei_pkg;

  // internal fixed point: unsigned Q8.56 in 64 bits
  localparam int FB = 56;
  localparam int QW = 64;
  typedef logic [QW-1:0] q_t;

  // field widths
  localparam int IN_W  = 53;
  localparam int K_W   = 45;
  localparam int E_W   = 42;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W = 53;
  localparam int SHIFT_W = 6;

  // parameter defaults
  localparam int IN_FRAC_BITS_DEF  = 52;
  localparam int OUT_FRAC_BITS_DEF = 40;
  localparam int NUM_TERMS = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COMP = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_MOD_RST  = 53'd4503599627;
  localparam logic [CFG_W-1:0] MIN_COMP_RST = 53'd2;

  // latency figures
  localparam int MUL_LAT   = 2;
  localparam int FRONT_LAT = 3;
  localparam int LOG_ITERS = FB;
  localparam int LOG_LAT   = LOG_ITERS * MUL_LAT + MUL_LAT;
  localparam int POLY_LAT  = (NUM_TERMS - 1) * MUL_LAT;
  localparam int TOTAL_LAT = FRONT_LAT + LOG_LAT + MUL_LAT + 1;

  // special-case flags carried along the pipeline
  typedef struct packed {
    logic invalid;
    logic zero;
    logic tiny;
  } flags_t;

  // floor(num / 10^p10 * 2^FB) by long division, for elaboration only
  function automatic q_t dec_to_q(input logic [63:0] num, input int p10);
    logic [63:0]  d;
    logic [127:0] n;
    logic [63:0]  r;
    logic [63:0]  q;
    d = 64'd1;
    for (int i = 0; i < p10; i++) d = d * 64'd10;
    n = {64'd0, num} << FB;
    r = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam q_t ONE_Q      = q_t'(1) << FB;
  localparam q_t ZERO_K_Q   = q_t'(13) << FB;
  localparam q_t LN2_Q      = dec_to_q(64'd69314718055994531, 17);

  localparam q_t K1_Q [NUM_TERMS] = '{
    dec_to_q(64'd30072519903687, 17), dec_to_q(64'd39684709020990, 16),
    dec_to_q(64'd10795990490592, 15), dec_to_q(64'd10589953620989, 15),
    dec_to_q(64'd75193867218084, 16), dec_to_q(64'd89266462945565, 16),
    dec_to_q(64'd14942029142282, 15), dec_to_q(64'd30885173001900, 15),
    dec_to_q(64'd96573590301742, 15), dec_to_q(64'd13862943611199, 13)};
  localparam q_t K2_Q [NUM_TERMS] = '{
    dec_to_q(64'd66631752464607, 18), dec_to_q(64'd17216147097987, 16),
    dec_to_q(64'd92811603829686, 16), dec_to_q(64'd20690240005101, 15),
    dec_to_q(64'd29503729348689, 15), dec_to_q(64'd37335546682286, 15),
    dec_to_q(64'd48827155048118, 15), dec_to_q(64'd70312495459547, 15),
    dec_to_q(64'd12499999999764, 14), dec_to_q(64'd50000000000000, 14)};
  localparam q_t E1_Q [NUM_TERMS-1] = '{
    dec_to_q(64'd32519201550639, 17), dec_to_q(64'd43025377747931, 16),
    dec_to_q(64'd11785841008734, 15), dec_to_q(64'd11841925995501, 15),
    dec_to_q(64'd90355277375409, 16), dec_to_q(64'd11716766944658, 15),
    dec_to_q(64'd21836131405487, 15), dec_to_q(64'd56805223329308, 15),
    dec_to_q(64'd44314718058337, 14)};
  localparam q_t E2_Q [NUM_TERMS-1] = '{
    dec_to_q(64'd72031696345716, 18), dec_to_q(64'd18645379184063, 16),
    dec_to_q(64'd10087958494375, 15), dec_to_q(64'd22660309891604, 15),
    dec_to_q(64'd32811069172721, 15), dec_to_q(64'd42672510126592, 15),
    dec_to_q(64'd58592707184265, 15), dec_to_q(64'd93749995116367, 15),
    dec_to_q(64'd24999999999746, 14)};

endpackage

`default_nettype wire

FILE: rtl/cei_mul.sv
// two-stage Q.56 multiplier with saturation: four 32x32 partial
// products, then recombine; uses cei_pkg
`default_nettype none

module cei_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  cei_pkg::q_t   a_i,
  input  cei_pkg::q_t   b_i,
  output cei_pkg::q_t   p_o
);
  import cei_pkg::*;

  logic [63:0] pp0_q, pp1_q, pp2_q, pp3_q;
  logic [33:0] mid;
  logic [65:0] hi;
  q_t          p_d, p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp0_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[31:0]};
      pp1_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[63:32]};
      pp2_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};
      pp3_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[63:32]};
    end
  end

  // recombine and drop the low 56 bits
  always_comb begin
    mid = {2'd0, pp0_q[63:32]} + {2'd0, pp1_q[31:0]} + {2'd0, pp2_q[31:0]};
    hi  = {2'd0, pp3_q} + {34'd0, pp1_q[63:32]} + {34'd0, pp2_q[63:32]}
        + {64'd0, mid[33:32]};
    if (|hi[65:56]) p_d = '1;
    else            p_d = {hi[55:0], mid[31:24]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/cei_dly.sv
// enabled delay line of fixed depth for sideband data
// no package dependency
`default_nettype none

module cei_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // shift one place per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule

`default_nettype wire

FILE: rtl/cei_front.sv
// input conditioning: threshold checks, scaling to Q.56, and a
// registered normalization (bit search, then shift); uses cei_pkg
`default_nettype none

module cei_front #(
  parameter int IN_FRAC_BITS = cei_pkg::IN_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [cei_pkg::IN_W-1:0]     modulus_sq_i,
  input  logic [cei_pkg::IN_W-1:0]     complement_sq_i,
  input  logic [cei_pkg::CFG_W-1:0]    min_mod_i,
  input  logic [cei_pkg::CFG_W-1:0]    min_comp_i,
  output cei_pkg::q_t                  x_o,
  output cei_pkg::q_t                  m_o,
  output logic [cei_pkg::SHIFT_W-1:0]  p_o,
  output cei_pkg::flags_t              flags_o
);
  import cei_pkg::*;

  localparam logic [63:0] ONE_IN = 64'd1 << IN_FRAC_BITS;

  logic [63:0] kd;
  q_t          x_sc;
  q_t          x1_d, x1_q, x2_q, x3_q, m3_q;
  flags_t      f1_d, f1_q, f2_q, f3_q;
  logic [SHIFT_W-1:0] p2_d, p2_q, p3_q;

  // clamp the complement to one and scale to Q.56
  always_comb begin
    kd = {11'd0, complement_sq_i};
    if (kd > ONE_IN) kd = ONE_IN;
    f1_d.invalid = modulus_sq_i < min_mod_i;
    f1_d.zero    = kd == 64'd0;
    f1_d.tiny    = kd < {11'd0, min_comp_i};
    x1_d = (x_sc == '0) ? q_t'(1) : x_sc;
  end

  if (IN_FRAC_BITS <= FB) begin : g_up
    assign x_sc = kd << (FB - IN_FRAC_BITS);
  end else begin : g_dn
    assign x_sc = kd >> (IN_FRAC_BITS - FB);
  end

  // leading one search
  always_comb begin
    p2_d = '0;
    for (int i = 0; i < QW; i++) begin
      if (x1_q[i]) p2_d = SHIFT_W'(i);
    end
  end

  // three register stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= x1_d;
      f1_q <= f1_d;
      x2_q <= x1_q;
      p2_q <= p2_d;
      f2_q <= f1_q;
      x3_q <= x2_q;
      p3_q <= p2_q;
      m3_q <= x2_q << (SHIFT_W'(FB) - p2_q);
      f3_q <= f2_q;
    end
  end

  assign x_o     = x3_q;
  assign m_o     = m3_q;
  assign p_o     = p3_q;
  assign flags_o = f3_q;

endmodule

`default_nettype wire

FILE: rtl/cei_log.sv
// -ln(x) in Q.56: 56 pipelined squaring steps give the log2 fraction,
// then one multiply by ln 2; uses cei_pkg, cei_mul, cei_dly
`default_nettype none

module cei_log (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  cei_pkg::q_t                  m_i,
  input  logic [cei_pkg::SHIFT_W-1:0]  p_i,
  output cei_pkg::q_t                  l_o
);
  import cei_pkg::*;

  q_t                 m_in  [LOG_ITERS+1];
  logic [FB-1:0]      f_in  [LOG_ITERS+1];
  logic [SHIFT_W-1:0] p_in  [LOG_ITERS+1];
  q_t                 sq    [LOG_ITERS];
  logic [FB-1:0]      f_d   [LOG_ITERS];
  logic [SHIFT_W-1:0] p_d   [LOG_ITERS];
  logic               hbit  [LOG_ITERS];
  q_t                 t;

  assign m_in[0] = m_i;
  assign f_in[0] = '0;
  assign p_in[0] = p_i;

  // one squaring step per two stages
  for (genvar g = 0; g < LOG_ITERS; g++) begin : g_step
    cei_mul u_sq (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (m_in[g]),
      .b_i   (m_in[g]),
      .p_o   (sq[g])
    );
    cei_dly #(.W(SHIFT_W + FB), .N(MUL_LAT)) u_side (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   ({p_in[g], f_in[g]}),
      .q_o   ({p_d[g], f_d[g]})
    );
    // renormalize when the square reaches two
    assign hbit[g]   = |sq[g][QW-1:FB+1];
    assign m_in[g+1] = hbit[g] ? {1'b0, sq[g][QW-1:1]} : sq[g];
    assign f_in[g+1] = f_d[g] | ({{(FB-1){1'b0}}, hbit[g]} << (FB - 1 - g));
    assign p_in[g+1] = p_d[g];
  end

  // integer part minus fraction, then scale by ln 2
  assign t = {2'd0, SHIFT_W'(FB) - p_in[LOG_ITERS], {FB{1'b0}}}
           - {{(QW-FB){1'b0}}, f_in[LOG_ITERS]};

  cei_mul u_ln2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (t),
    .b_i   (LN2_Q),
    .p_o   (l_o)
  );

endmodule

`default_nettype wire

FILE: rtl/cei_poly.sv
// Horner evaluation of the four polynomials in x, one term per two
// stages, delayed to line up with the log; uses cei_pkg, cei_mul, cei_dly
`default_nettype none

module cei_poly (
  input  logic            clk_i,
  input  logic            en_i,
  input  cei_pkg::q_t     x_i,
  input  cei_pkg::flags_t flags_i,
  output cei_pkg::q_t     s1_o,
  output cei_pkg::q_t     s2_o,
  output cei_pkg::q_t     e1_o,
  output cei_pkg::q_t     e2_o,
  output cei_pkg::flags_t flags_o
);
  import cei_pkg::*;

  localparam int STEPS = NUM_TERMS - 1;
  localparam int SW    = QW + $bits(flags_t);
  localparam int TW    = 4 * QW + $bits(flags_t);

  q_t     s1 [STEPS+1];
  q_t     s2 [STEPS+1];
  q_t     e1 [STEPS+1];
  q_t     e2 [STEPS+1];
  q_t     xs [STEPS+1];
  flags_t fs [STEPS+1];
  q_t     ps1 [STEPS];
  q_t     ps2 [STEPS];

  assign s1[0] = K1_Q[0];
  assign s2[0] = K2_Q[0];
  assign e1[0] = '0;
  assign e2[0] = '0;
  assign xs[0] = x_i;
  assign fs[0] = flags_i;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    cei_mul u_s1 (.clk_i(clk_i), .en_i(en_i), .a_i(s1[g]), .b_i(xs[g]), .p_o(ps1[g]));
    cei_mul u_s2 (.clk_i(clk_i), .en_i(en_i), .a_i(s2[g]), .b_i(xs[g]), .p_o(ps2[g]));
    // the second-kind terms add before the multiply
    cei_mul u_e1 (.clk_i(clk_i), .en_i(en_i), .a_i(e1[g] + E1_Q[g]), .b_i(xs[g]),
                  .p_o(e1[g+1]));
    cei_mul u_e2 (.clk_i(clk_i), .en_i(en_i), .a_i(e2[g] + E2_Q[g]), .b_i(xs[g]),
                  .p_o(e2[g+1]));
    cei_dly #(.W(SW), .N(MUL_LAT)) u_side (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   ({xs[g], fs[g]}),
      .q_o   ({xs[g+1], fs[g+1]})
    );
    assign s1[g+1] = ps1[g] + K1_Q[g+1];
    assign s2[g+1] = ps2[g] + K2_Q[g+1];
  end

  // hold results until the log is done
  cei_dly #(.W(TW), .N(LOG_LAT - POLY_LAT)) u_tail (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({s1[STEPS], s2[STEPS], e1[STEPS], e2[STEPS], fs[STEPS]}),
    .q_o   ({s1_o, s2_o, e1_o, e2_o, flags_o})
  );

endmodule

`default_nettype wire

FILE: rtl/complete_elliptic_integrals.sv
// Complete elliptic integrals K and E, fully pipelined.
// A request passes the front stages, the log, the final multiply and the
// output register; the log with its 56 squaring steps is the longest.
// Throughput: one request per cycle; a stalled result freezes the pipeline.
// Reset: asynchronous active low, clears valid bits and loads register
// defaults; data registers are not reset.
`default_nettype none

module complete_elliptic_integrals #(
  parameter int IN_FRAC_BITS  = cei_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = cei_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cei_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cei_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cei_pkg::IN_W-1:0]       modulus_sq_i,
  input  logic [cei_pkg::IN_W-1:0]       complement_sq_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cei_pkg::K_W-1:0]        k_value_o,
  output logic [cei_pkg::E_W-1:0]        e_value_o,
  output logic                           valid_res_o
);
  import cei_pkg::*;

  localparam q_t K_MAX = (q_t'(1) << K_W) - q_t'(1);
  localparam q_t E_MAX = (q_t'(1) << E_W) - q_t'(1);
  localparam int OSH   = FB - OUT_FRAC_BITS;

  logic [CFG_W-1:0] min_mod_q, min_comp_q;
  logic             en;
  logic [TOTAL_LAT-1:0] v_q;

  q_t                 x_f, m_f, l_v;
  logic [SHIFT_W-1:0] p_f;
  flags_t             fl_f, fl_p, fl_o;
  q_t                 s1_p, s2_p, e1_p, e2_p;
  q_t                 s1_o, e1_o, lk, le;
  q_t                 kv, ev, kr, er;
  logic [K_W-1:0]     k_d, k_q;
  logic [E_W-1:0]     e_d, e_q;
  logic               r_d, r_q;

  // the whole pipeline advances unless a result is held
  assign en         = !(v_q[TOTAL_LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mod_q  <= MIN_MOD_RST;
      min_comp_q <= MIN_COMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_MOD:  min_mod_q  <= cfg_data_i;
        REG_MIN_COMP: min_comp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  cei_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
    .clk_i           (clk_i),
    .en_i            (en),
    .modulus_sq_i    (modulus_sq_i),
    .complement_sq_i (complement_sq_i),
    .min_mod_i       (min_mod_q),
    .min_comp_i      (min_comp_q),
    .x_o             (x_f),
    .m_o             (m_f),
    .p_o             (p_f),
    .flags_o         (fl_f)
  );

  cei_log u_log (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (m_f),
    .p_i   (p_f),
    .l_o   (l_v)
  );

  cei_poly u_poly (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_f),
    .flags_i (fl_f),
    .s1_o    (s1_p),
    .s2_o    (s2_p),
    .e1_o    (e1_p),
    .e2_o    (e2_p),
    .flags_o (fl_p)
  );

  // log terms; a tiny complement keeps only the constant terms
  cei_mul u_lk (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (l_v),
    .b_i   (fl_p.tiny ? K2_Q[NUM_TERMS-1] : s2_p),
    .p_o   (lk)
  );

  cei_mul u_le (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (l_v),
    .b_i   (e2_p),
    .p_o   (le)
  );

  cei_dly #(.W(2 * QW + $bits(flags_t)), .N(MUL_LAT)) u_side (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({fl_p.tiny ? K1_Q[NUM_TERMS-1] : s1_p, e1_p, fl_p}),
    .q_o   ({s1_o, e1_o, fl_o})
  );

  // final sums, special cases and saturation
  always_comb begin
    kv = s1_o + lk;
    ev = ONE_Q + e1_o + le;
    if (fl_o.zero) begin
      kv = ZERO_K_Q;
      ev = ONE_Q;
    end else if (fl_o.tiny) begin
      ev = ONE_Q;
    end
    kr  = kv >> OSH;
    er  = ev >> OSH;
    k_d = (kr > K_MAX) ? K_MAX[K_W-1:0] : kr[K_W-1:0];
    e_d = (er > E_MAX) ? E_MAX[E_W-1:0] : er[E_W-1:0];
    r_d = 1'b1;
    if (fl_o.invalid) begin
      k_d = '0;
      e_d = '0;
      r_d = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q <= k_d;
      e_q <= e_d;
      r_q <= r_d;
    end
  end

  assign out_valid_o = v_q[TOTAL_LAT-1];
  assign k_value_o   = k_q;
  assign e_value_o   = e_q;
  assign valid_res_o = r_q;

endmodule

`default_nettype wire

FILE: rtl/cei_checker.sv
// port-level checks for the elliptic integral block, attached by bind
// uses cei_pkg
`default_nettype none

module cei_checker #(
  parameter int OUT_FRAC_BITS = cei_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [cei_pkg::K_W-1:0]       k_value_o,
  input logic [cei_pkg::E_W-1:0]       e_value_o,
  input logic                          valid_res_o
);
  import cei_pkg::*;

  localparam logic [63:0] E_ONE = (OUT_FRAC_BITS < E_W) ?
    (64'd1 << OUT_FRAC_BITS) : ((64'd1 << E_W) - 64'd1);

  // a held result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input stalls only behind a held result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // an invalid modulus gives zero integrals
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> k_value_o == '0 && e_value_o == '0)
    else $error("invalid result carries nonzero values");

  // E is never below one on a valid result
  a_eone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> {22'd0, e_value_o} >= E_ONE)
    else $error("second-kind integral below one");

endmodule

bind complete_elliptic_integrals cei_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_cei_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .k_value_o   (k_value_o),
  .e_value_o   (e_value_o),
  .valid_res_o (valid_res_o)
);

`default_nettype wire
